@@ src/perlin_noise_fbm_height_core_assert.svh @@
// Assertion macros used by the height core top level.
`ifndef PERLIN_NOISE_FBM_HEIGHT_CORE_ASSERT_SVH
`define PERLIN_NOISE_FBM_HEIGHT_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PNF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PNF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/pnf_pkg.sv @@
// Shared types and constants of the Perlin fBm height core.
package pnf_pkg;

    localparam int COORD_W  = 12;
    localparam int FREQ_W   = 32;
    localparam int AMP_W    = 24;
    localparam int HEIGHT_W = 28;
    localparam int POS_W    = COORD_W + FREQ_W;
    localparam int FRAC_W   = 16;
    localparam int NOISE_W  = 22;
    localparam int OCT_NUM  = 6;
    localparam int TIDX_W   = 9;
    localparam int TVAL_W   = 8;

    // Request kinds carried in tuser.
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_TABLE  = 1'b1;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_FREQUENCY  = 2'd0,
        REG_AMPLITUDE  = 2'd1,
        REG_FBM_ENABLE = 2'd2
    } cfg_reg_t;

    // Octave weights round(65536 / (p ln p)) for p = 2, 4, 8, 16, 32.
    localparam logic [15:0] OCT_WEIGHT [OCT_NUM-1] = '{
        16'd47274, 16'd11819, 16'd3940, 16'd1477, 16'd591
    };

    // One permutation table write traveling down the pipeline.
    typedef struct packed {
        logic              vld;
        logic [TIDX_W-1:0] idx;
        logic [TVAL_W-1:0] val;
    } perm_wr_t;

endpackage

@@ src/pnf_perm_ram.sv @@
// Permutation table copy with one write port and two registered read ports.
module pnf_perm_ram
    import pnf_pkg::*;
#(
    parameter int AW = 9
)
(
    input  logic              clk,
    input  logic              en,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [TVAL_W-1:0] wdata,
    input  logic [AW-1:0]     raddr0,
    input  logic [AW-1:0]     raddr1,
    output logic [TVAL_W-1:0] rdata0,
    output logic [TVAL_W-1:0] rdata1
);

    logic [TVAL_W-1:0] mem_reg [2**AW];
    logic [TVAL_W-1:0] rdata0_reg;
    logic [TVAL_W-1:0] rdata1_reg;

    // Reads see the contents from before a write in the same cycle.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[waddr] <= wdata;
            end
            rdata0_reg <= mem_reg[raddr0];
            rdata1_reg <= mem_reg[raddr1];
        end
    end

    assign rdata0 = rdata0_reg;
    assign rdata1 = rdata1_reg;

endmodule

@@ src/pnf_octave.sv @@
// One noise octave: hashing, gradients, quintic fade and bilinear lerp.
module pnf_octave
    import pnf_pkg::*;
#(
    parameter int PERM_SIZE = 256,
    parameter int SHIFT     = 0
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic [POS_W-1:0]          px,
    input  logic [POS_W-1:0]          py,
    input  perm_wr_t                  wr,
    output logic signed [NOISE_W-1:0] noise
);

    localparam int PB = $clog2(PERM_SIZE);
    localparam int AW = PB + 1;
    localparam int SW = ((AW > TVAL_W) ? AW : TVAL_W) + 1;

    function automatic logic signed [18:0] grad(input logic [1:0] h,
                                                input logic signed [18:0] dx,
                                                input logic signed [18:0] dy);
        logic signed [18:0] r;
        unique case (h)
            2'd0: r = dx + dy;
            2'd1: r = dy - dx;
            2'd2: r = dx - dy;
            default: r = -dx - dy;
        endcase
        return r;
    endfunction

    // Lattice cell and fraction of this octave's position.
    logic [PB-1:0]     xi;
    logic [PB-1:0]     yi;
    logic [AW-1:0]     x0_addr;
    logic [AW-1:0]     x1_addr;
    assign xi      = px[28-SHIFT +: PB];
    assign yi      = py[28-SHIFT +: PB];
    assign x0_addr = AW'(xi);
    assign x1_addr = AW'(xi) + AW'(1);

    // Stage 3: first hash level, write commit for the first table copy.
    logic [PB-1:0]     yi3_reg;
    logic [FRAC_W-1:0] t3_reg [2];
    perm_wr_t          wr3_reg;
    logic [TVAL_W-1:0] hx0;
    logic [TVAL_W-1:0] hx1;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            yi3_reg   <= yi;
            t3_reg[0] <= px[12-SHIFT +: FRAC_W];
            t3_reg[1] <= py[12-SHIFT +: FRAC_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr3_reg <= '0;
        end
        else if (en)
        begin
            wr3_reg <= wr;
        end
    end

    pnf_perm_ram #(.AW(AW)) u_ram_x
    (
        .clk    (clk),
        .en     (en),
        .we     (wr.vld),
        .waddr  (AW'(wr.idx)),
        .wdata  (wr.val),
        .raddr0 (x0_addr),
        .raddr1 (x1_addr),
        .rdata0 (hx0),
        .rdata1 (hx1)
    );

    // Corner addresses wrap modulo the table depth.
    logic [SW-1:0] s00;
    logic [SW-1:0] s01;
    logic [SW-1:0] s10;
    logic [SW-1:0] s11;
    assign s00 = SW'(hx0) + SW'(yi3_reg);
    assign s01 = s00 + SW'(1);
    assign s10 = SW'(hx1) + SW'(yi3_reg);
    assign s11 = s10 + SW'(1);

    // Stage 4: corner hashes, fade first step.
    logic [TVAL_W-1:0] h_bl;
    logic [TVAL_W-1:0] h_tl;
    logic [TVAL_W-1:0] h_br;
    logic [TVAL_W-1:0] h_tr;
    logic [FRAC_W-1:0] t4_reg  [2];
    logic [19:0]       fa4_reg [2];
    logic [15:0]       tt4_reg [2];
    logic [31:0]       tt_sq   [2];

    pnf_perm_ram #(.AW(AW)) u_ram_l
    (
        .clk    (clk),
        .en     (en),
        .we     (wr3_reg.vld),
        .waddr  (AW'(wr3_reg.idx)),
        .wdata  (wr3_reg.val),
        .raddr0 (s00[AW-1:0]),
        .raddr1 (s01[AW-1:0]),
        .rdata0 (h_bl),
        .rdata1 (h_tl)
    );

    pnf_perm_ram #(.AW(AW)) u_ram_r
    (
        .clk    (clk),
        .en     (en),
        .we     (wr3_reg.vld),
        .waddr  (AW'(wr3_reg.idx)),
        .wdata  (wr3_reg.val),
        .raddr0 (s10[AW-1:0]),
        .raddr1 (s11[AW-1:0]),
        .rdata0 (h_br),
        .rdata1 (h_tr)
    );

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            tt_sq[i] = 32'(t3_reg[i]) * 32'(t3_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 2; i++)
            begin
                t4_reg[i]  <= t3_reg[i];
                fa4_reg[i] <= 20'd983040 - (20'(t3_reg[i]) * 20'd6);
                tt4_reg[i] <= tt_sq[i][31:16];
            end
        end
    end

    // Stage 5: gradient dot products, fade second step.
    logic signed [18:0] dx0;
    logic signed [18:0] dx1;
    logic signed [18:0] dy0;
    logic signed [18:0] dy1;
    logic [35:0]        fb_prod [2];
    logic [31:0]        fc_prod [2];
    logic [19:0]        fb5_reg [2];
    logic [15:0]        fc5_reg [2];
    logic signed [18:0] d_bl5_reg;
    logic signed [18:0] d_tl5_reg;
    logic signed [18:0] d_br5_reg;
    logic signed [18:0] d_tr5_reg;

    assign dx0 = $signed({3'b000, t4_reg[0]});
    assign dx1 = dx0 - 19'sd65536;
    assign dy0 = $signed({3'b000, t4_reg[1]});
    assign dy1 = dy0 - 19'sd65536;

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            fb_prod[i] = 36'(t4_reg[i]) * 36'(fa4_reg[i]);
            fc_prod[i] = 32'(tt4_reg[i]) * 32'(t4_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 2; i++)
            begin
                fb5_reg[i] <= fb_prod[i][35:16];
                fc5_reg[i] <= fc_prod[i][31:16];
            end
            d_bl5_reg <= grad(h_bl[1:0], dx0, dy0);
            d_br5_reg <= grad(h_br[1:0], dx1, dy0);
            d_tr5_reg <= grad(h_tr[1:0], dx1, dy1);
            d_tl5_reg <= grad(h_tl[1:0], dx0, dy1);
        end
    end

    // Stage 6: fade third step, edge differences for the first lerps.
    logic [19:0]        fcc6_reg [2];
    logic [15:0]        fc6_reg  [2];
    logic signed [19:0] dl6_reg;
    logic signed [19:0] dr6_reg;
    logic signed [18:0] d_bl6_reg;
    logic signed [18:0] d_br6_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 2; i++)
            begin
                fcc6_reg[i] <= 20'd655360 - fb5_reg[i];
                fc6_reg[i]  <= fc5_reg[i];
            end
            dl6_reg   <= 20'(d_tl5_reg) - 20'(d_bl5_reg);
            dr6_reg   <= 20'(d_tr5_reg) - 20'(d_br5_reg);
            d_bl6_reg <= d_bl5_reg;
            d_br6_reg <= d_br5_reg;
        end
    end

    // Stage 7: fade result u and v.
    logic [35:0]        fd_prod [2];
    logic [19:0]        u7_reg;
    logic [19:0]        v7_reg;
    logic signed [19:0] dl7_reg;
    logic signed [19:0] dr7_reg;
    logic signed [18:0] d_bl7_reg;
    logic signed [18:0] d_br7_reg;

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            fd_prod[i] = 36'(fc6_reg[i]) * 36'(fcc6_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u7_reg    <= fd_prod[0][35:16];
            v7_reg    <= fd_prod[1][35:16];
            dl7_reg   <= dl6_reg;
            dr7_reg   <= dr6_reg;
            d_bl7_reg <= d_bl6_reg;
            d_br7_reg <= d_br6_reg;
        end
    end

    // Stage 8: vertical lerp products.
    logic signed [40:0] pl8_reg;
    logic signed [40:0] pr8_reg;
    logic signed [18:0] d_bl8_reg;
    logic signed [18:0] d_br8_reg;
    logic [19:0]        u8_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pl8_reg   <= $signed({1'b0, v7_reg}) * dl7_reg;
            pr8_reg   <= $signed({1'b0, v7_reg}) * dr7_reg;
            d_bl8_reg <= d_bl7_reg;
            d_br8_reg <= d_br7_reg;
            u8_reg    <= u7_reg;
        end
    end

    // Stage 9: vertical lerp sums with floor rounding.
    logic signed [NOISE_W-1:0] la9_reg;
    logic signed [NOISE_W-1:0] lb9_reg;
    logic [19:0]               u9_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            la9_reg <= NOISE_W'(d_bl8_reg) + NOISE_W'(pl8_reg >>> 16);
            lb9_reg <= NOISE_W'(d_br8_reg) + NOISE_W'(pr8_reg >>> 16);
            u9_reg  <= u8_reg;
        end
    end

    // Stage 10: horizontal difference.
    logic signed [NOISE_W:0]   dh10_reg;
    logic signed [NOISE_W-1:0] la10_reg;
    logic [19:0]               u10_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dh10_reg <= (NOISE_W+1)'(lb9_reg) - (NOISE_W+1)'(la9_reg);
            la10_reg <= la9_reg;
            u10_reg  <= u9_reg;
        end
    end

    // Stage 11: horizontal lerp product.
    logic signed [NOISE_W+21:0] ph11_reg;
    logic signed [NOISE_W-1:0]  la11_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ph11_reg <= $signed({1'b0, u10_reg}) * dh10_reg;
            la11_reg <= la10_reg;
        end
    end

    // Stage 12: octave noise value in Q.16.
    logic signed [NOISE_W-1:0] noise12_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            noise12_reg <= la11_reg + NOISE_W'(ph11_reg >>> 16);
        end
    end

    assign noise = noise12_reg;

endmodule

@@ src/perlin_noise_fbm_height_core.sv @@
// An accepted sample request passes through every pipeline stage up to the output register.
// Throughput: one request per cycle while no result is held; table writes flow through and give no result.
// A stalled output holds the whole pipeline; bubbles and table writes travel down it like samples.
// Reset clears valid bits and sets frequency 0, amplitude 1.0, fBm off.
// The permutation table copies are not cleared and must be written before use.
// Top level of the Perlin fBm height core.
`include "perlin_noise_fbm_height_core_assert.svh"

module perlin_noise_fbm_height_core
    import pnf_pkg::*;
#(
    parameter int PERM_SIZE = 256,
    parameter int MAX_GRID  = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // coord_x, coord_y, table_index, table_value
    input  logic        s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // height
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_wdata
);

    localparam int STAGES = 17;

    // Configuration registers.
    logic [FREQ_W-1:0] freq_reg;
    logic [AMP_W-1:0]  amp_reg;
    logic              fbm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_reg <= '0;
            amp_reg  <= AMP_W'(65536);
            fbm_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_FREQUENCY:  freq_reg <= cfg_wdata;
                REG_AMPLITUDE:  amp_reg  <= cfg_wdata[AMP_W-1:0];
                REG_FBM_ENABLE: fbm_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // The whole pipeline advances unless a finished result is held.
    logic en;
    logic [STAGES:1] smp_vld_reg;
    assign en       = !smp_vld_reg[STAGES] || m_tready;
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smp_vld_reg <= '0;
        end
        else if (en)
        begin
            smp_vld_reg <= {smp_vld_reg[STAGES-1:1], s_tvalid && (s_tuser == REQ_SAMPLE)};
        end
    end

    // Stage 1: clamp coordinates, capture table writes.
    logic [COORD_W-1:0] in_x;
    logic [COORD_W-1:0] in_y;
    logic [COORD_W-1:0] cx1_reg;
    logic [COORD_W-1:0] cy1_reg;
    perm_wr_t           wr1_reg;
    perm_wr_t           wr2_reg;

    assign in_x = s_tdata[11:0];
    assign in_y = s_tdata[23:12];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cx1_reg <= (32'(in_x) > 32'(MAX_GRID - 1)) ? COORD_W'(MAX_GRID - 1) : in_x;
            cy1_reg <= (32'(in_y) > 32'(MAX_GRID - 1)) ? COORD_W'(MAX_GRID - 1) : in_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr1_reg <= '0;
            wr2_reg <= '0;
        end
        else if (en)
        begin
            wr1_reg.vld <= s_tvalid && (s_tuser == REQ_TABLE);
            wr1_reg.idx <= s_tdata[32:24];
            wr1_reg.val <= s_tdata[40:33];
            wr2_reg     <= wr1_reg;
        end
    end

    // Stage 2: base-octave position; higher octaves are shifts of it.
    logic [POS_W-1:0] px2_reg;
    logic [POS_W-1:0] py2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px2_reg <= POS_W'(cx1_reg) * POS_W'(freq_reg);
            py2_reg <= POS_W'(cy1_reg) * POS_W'(freq_reg);
        end
    end

    // Stages 3 to 12: one lane per octave.
    logic signed [NOISE_W-1:0] noise [OCT_NUM];

    for (genvar k = 0; k < OCT_NUM; k++)
    begin : g_oct
        pnf_octave #(.PERM_SIZE(PERM_SIZE), .SHIFT(k)) u_oct
        (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .px    (px2_reg),
            .py    (py2_reg),
            .wr    (wr2_reg),
            .noise (noise[k])
        );
    end

    // Stage 13: scale by amplitude.
    logic signed [NOISE_W+AMP_W:0] amp13_reg [OCT_NUM];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < OCT_NUM; k++)
            begin
                amp13_reg[k] <= noise[k] * $signed({1'b0, amp_reg});
            end
        end
    end

    // Stage 14: base octave shifted down, fractal octaves weighted.
    logic signed [63:0] w14_reg [OCT_NUM];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w14_reg[0] <= 64'(amp13_reg[0] >>> 16);
            for (int k = 1; k < OCT_NUM; k++)
            begin
                w14_reg[k] <= 64'(amp13_reg[k]) * 64'($signed({1'b0, OCT_WEIGHT[k-1]}));
            end
        end
    end

    // Stage 15: per-octave terms; fractal terms drop out when fBm is off.
    logic signed [31:0] term15_reg [OCT_NUM];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            term15_reg[0] <= w14_reg[0][31:0];
            for (int k = 1; k < OCT_NUM; k++)
            begin
                term15_reg[k] <= fbm_reg ? w14_reg[k][63:32] : 32'sd0;
            end
        end
    end

    // Stage 16: pairwise sums.
    logic signed [32:0] pair16_reg [OCT_NUM/2];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < OCT_NUM / 2; k++)
            begin
                pair16_reg[k] <= 33'(term15_reg[2*k]) + 33'(term15_reg[2*k+1]);
            end
        end
    end

    // Stage 17: final sum with saturation into the output register.
    logic signed [34:0]         total;
    logic signed [HEIGHT_W-1:0] height_reg;
    logic signed [HEIGHT_W-1:0] height_next;

    assign total = 35'(pair16_reg[0]) + 35'(pair16_reg[1]) + 35'(pair16_reg[2]);

    always_comb
    begin
        priority if (total > 35'sd134217727)
        begin
            height_next = {1'b0, {(HEIGHT_W-1){1'b1}}};
        end
        else if (total < -35'sd134217728)
        begin
            height_next = {1'b1, {(HEIGHT_W-1){1'b0}}};
        end
        else
        begin
            height_next = total[HEIGHT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            height_reg <= height_next;
        end
    end

    assign m_tvalid = smp_vld_reg[STAGES];
    assign m_tdata  = {4'b0000, height_reg};

    // A held result must block new requests.
    `PNF_ASSERT_SAME(a_hold_blocks_input, smp_vld_reg[STAGES] && !m_tready, !s_tready, "input accepted while result held")
    // A sample in the next-to-last stage becomes a result after an advance.
    `PNF_ASSERT_NEXT(a_result_follows, en && smp_vld_reg[STAGES-1], m_tvalid, "sample lost before output")
    // A stall keeps every valid bit in place.
    `PNF_ASSERT_NEXT(a_stall_holds, !en, $stable(smp_vld_reg), "valid bits changed during stall")

endmodule

@@ sim/perlin_noise_fbm_height_core_tb.sv @@
// Self-checking testbench of the Perlin fBm height core with a bit-exact height predictor.
`timescale 1ns / 100ps

module perlin_noise_fbm_height_core_tb;
    import pnf_pkg::*;

    localparam int PERM_N  = 256;
    localparam int PERM_D  = 2 * PERM_N;
    localparam int LATENCY = 17;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [31:0] cfg_wdata;

    // Predictor copy of the configuration and the permutation store.
    logic [31:0] freq_q;
    logic [23:0] amp_q;
    logic        fbm_q;
    logic [7:0]  perm_q [PERM_D];

    logic [27:0] height_q [$];
    int          errors;
    int          mismatches;
    int          samples_sent;
    int          writes_sent;
    int          results_seen;
    int          send_idle_pct;
    int          recv_idle_pct;

    perlin_noise_fbm_height_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("Timeout at %0t", $realtime);
        $display("CHECKS FAILED");
        $finish;
    end

    // Arithmetic shift right rounds toward minus infinity on signed values.
    function automatic longint fshr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint fade16(longint t);
        longint a;
        longint b;
        longint c;
        longint t3;
        a  = (longint'(15) << 16) - 6 * t;
        b  = (t * a) >>> 16;
        c  = (longint'(10) << 16) - b;
        t3 = (((t * t) >>> 16) * t) >>> 16;
        return (t3 * c) >>> 16;
    endfunction

    function automatic longint blend16(longint t, longint a, longint b);
        return a + fshr(t * (b - a), 16);
    endfunction

    function automatic longint corner_dot(logic [7:0] h, longint dx, longint dy);
        case (h[1:0])
            2'd0:    return dx + dy;
            2'd1:    return -dx + dy;
            2'd2:    return dx - dy;
            default: return -dx - dy;
        endcase
    endfunction

    function automatic logic [7:0] perm_at(longint addr);
        return perm_q[addr % PERM_D];
    endfunction

    function automatic longint octave_noise(longint cx, longint cy, longint mult);
        logic [63:0] px;
        logic [63:0] py;
        longint      xi;
        longint      yi;
        longint      xf;
        longint      yf;
        longint      h0;
        longint      h1;
        longint      one;
        longint      dbl;
        longint      dbr;
        longint      dtr;
        longint      dtl;
        px  = cx * longint'(freq_q) * mult;
        py  = cy * longint'(freq_q) * mult;
        xi  = (px >> 28) % PERM_N;
        yi  = (py >> 28) % PERM_N;
        xf  = px[27:12];
        yf  = py[27:12];
        one = 65536;
        h0  = perm_at(xi);
        h1  = perm_at(xi + 1);
        dbl = corner_dot(perm_at(h0 + yi), xf, yf);
        dbr = corner_dot(perm_at(h1 + yi), xf - one, yf);
        dtr = corner_dot(perm_at(h1 + yi + 1), xf - one, yf - one);
        dtl = corner_dot(perm_at(h0 + yi + 1), xf, yf - one);
        return blend16(fade16(xf), blend16(fade16(yf), dbl, dtl),
                       blend16(fade16(yf), dbr, dtr));
    endfunction

    function automatic logic [27:0] height_of(logic [11:0] x, logic [11:0] y);
        longint sum;
        longint amp;
        amp = amp_q;
        sum = fshr(octave_noise(x, y, 1) * amp, 16);
        if (fbm_q)
        begin
            for (int k = 0; k < 5; k++)
                sum += fshr(octave_noise(x, y, longint'(2) << k) * amp
                            * longint'(OCT_WEIGHT[k]), 32);
        end
        if (sum > 134217727)
            sum = 134217727;
        if (sum < -134217728)
            sum = -134217728;
        return sum[27:0];
    endfunction

    // Send one request; track the predicted result on acceptance.
    task automatic send_request(logic kind, logic [11:0] x, logic [11:0] y,
                                logic [8:0] idx, logic [7:0] val);
        while ($urandom_range(99) < send_idle_pct)
            @(negedge clk);
        s_tvalid = 1'b1;
        s_tuser  = kind;
        s_tdata  = {7'd0, val, idx, y, x};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (kind == REQ_TABLE)
        begin
            perm_q[idx % PERM_D] = val;
            writes_sent++;
        end
        else
        begin
            height_q.push_back(height_of(x, y));
            samples_sent++;
        end
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    task automatic drain_and_settle();
        while (height_q.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    task automatic write_reg(cfg_reg_t r, logic [31:0] v);
        cfg_we    = 1'b1;
        cfg_addr  = r;
        cfg_wdata = v;
        @(negedge clk);
        cfg_we    = 1'b0;
        case (r)
            REG_FREQUENCY:  freq_q = v;
            REG_AMPLITUDE:  amp_q = v[23:0];
            REG_FBM_ENABLE: fbm_q = v[0];
            default: ;
        endcase
    endtask

    task automatic sample_random();
        send_request(REQ_SAMPLE, 12'($urandom), 12'($urandom), 9'($urandom), 8'($urandom));
    endtask

    // Result checker.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (height_q.size() == 0)
            begin
                errors++;
                if (mismatches++ < 10)
                    $display("Unexpected height %h", m_tdata[27:0]);
            end
            else if (height_q[0] !== m_tdata[27:0])
            begin
                errors++;
                if (mismatches++ < 10)
                    $display("Height mismatch: expected %h actual %h",
                             height_q[0], m_tdata[27:0]);
                void'(height_q.pop_front());
            end
            else
                void'(height_q.pop_front());
        end
    end

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    // Fill the whole table with random content.
    task automatic test_table_fill();
        for (int i = 0; i < PERM_D; i++)
            send_request(REQ_TABLE, 12'($urandom), 12'($urandom), 9'(i), 8'($urandom));
    endtask

    task automatic test_directed();
        write_reg(REG_FREQUENCY, 32'h0100_0000);
        send_request(REQ_SAMPLE, 12'd0, 12'd0, 9'h1FF, 8'hFF);
        send_request(REQ_SAMPLE, 12'hFFF, 12'hFFF, 9'd0, 8'd0);
        send_request(REQ_SAMPLE, 12'hFFF, 12'd0, 9'h155, 8'hAA);
        send_request(REQ_SAMPLE, 12'd0, 12'hFFF, 9'h0AA, 8'h55);
        send_request(REQ_TABLE, 12'hFFF, 12'hFFF, 9'h1FF, 8'hFF);
        send_request(REQ_TABLE, 12'd0, 12'd0, 9'd0, 8'd0);
        send_request(REQ_SAMPLE, 12'd1, 12'd3, 9'd0, 8'd0);
        drain_and_settle();
        // Extreme frequency and amplitude, with and without octaves.
        write_reg(REG_FREQUENCY, 32'hFFFF_FFFF);
        write_reg(REG_AMPLITUDE, 32'h00FF_FFFF);
        send_request(REQ_SAMPLE, 12'hFFF, 12'hFFF, 9'd0, 8'd0);
        send_request(REQ_SAMPLE, 12'd7, 12'd5, 9'd0, 8'd0);
        drain_and_settle();
        write_reg(REG_FBM_ENABLE, 32'd1);
        for (int i = 0; i < 6; i++)
            sample_random();
        drain_and_settle();
        write_reg(REG_AMPLITUDE, 32'd0);
        send_request(REQ_SAMPLE, 12'd100, 12'd200, 9'd0, 8'd0);
        drain_and_settle();
        // An unused register index must leave the configuration alone.
        cfg_we <= 1'b1;
        cfg_addr <= 2'd3;
        cfg_wdata <= 32'hFFFF_FFFF;
        @(negedge clk);
        cfg_we <= 1'b0;
        send_request(REQ_SAMPLE, 12'd9, 12'd9, 9'd0, 8'd0);
        drain_and_settle();
    endtask

    // Random mix of samples and table rewrites under the current settings.
    task automatic test_random(int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(9) == 0)
                send_request(REQ_TABLE, 12'($urandom), 12'($urandom),
                             9'($urandom), 8'($urandom));
            else
                sample_random();
        end
        drain_and_settle();
    endtask

    task automatic random_settings();
        case ($urandom_range(3))
            0:       write_reg(REG_FREQUENCY, $urandom);
            1:       write_reg(REG_FREQUENCY, 32'($urandom_range(32'h0400_0000)));
            default: write_reg(REG_FREQUENCY, 32'($urandom_range(32'h0040_0000)));
        endcase
        write_reg(REG_AMPLITUDE, 32'($urandom_range(24'hFF_FFFF)));
        write_reg(REG_FBM_ENABLE, 32'($urandom_range(1)));
    endtask

    initial
    begin
        errors = 0; mismatches = 0; samples_sent = 0; writes_sent = 0; results_seen = 0;
        freq_q = 32'd0; amp_q = 24'h01_0000; fbm_q = 1'b0;
        send_idle_pct = 6; recv_idle_pct = 62;
        rst_n = 1'b0; s_tvalid = 1'b0; s_tdata = '0; s_tuser = 1'b0;
        m_tready = 1'b0; cfg_we = 1'b0; cfg_addr = '0; cfg_wdata = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_table_fill();
        drain_and_settle();
        test_directed();
        for (int ph = 0; ph < 9; ph++)
        begin
            if (ph == 3)
            begin
                send_idle_pct = 62; recv_idle_pct = 6;
            end
            if (ph == 6)
            begin
                send_idle_pct = 0; recv_idle_pct = 0;
            end
            random_settings();
            test_random(60);
        end
        drain_and_settle();
        $display("Covered %0d samples and %0d table writes, %0d heights checked.",
                 samples_sent, writes_sent, results_seen);
        if (errors == 0 && height_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

@@ perlin_noise_fbm_height_core.f @@
+incdir+src
src/pnf_pkg.sv
src/pnf_perm_ram.sv
src/pnf_octave.sv
src/perlin_noise_fbm_height_core.sv
sim/perlin_noise_fbm_height_core_tb.sv
